@@ design/ptm_pkg.sv @@
package ptm_pkg;

    localparam int PAGE_W  = 8;
    localparam int FRAME_W = 6;
    localparam int PAGES   = 1 << PAGE_W;
    localparam int FRAMES  = 1 << FRAME_W;
    localparam int CNT_W   = FRAME_W + 1;
    localparam int ADDR_W  = 3;

    localparam logic [ADDR_W-1:0] REG_NUM_FRAMES = 3'd0;
    localparam logic [CNT_W-1:0]  NUM_FRAMES_RST = CNT_W'(FRAMES);

    typedef enum logic [2:0] {
        OP_INSERT     = 3'd0,
        OP_LOOKUP     = 3'd1,
        OP_REMOVE     = 3'd2,
        OP_INVALIDATE = 3'd3,
        OP_REPLACE    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_FRAME = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_BUSY      = 3'd3,
        STAT_MAPPED    = 3'd4,
        STAT_FAULT     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_REP_RD,
        ST_REP_CHK
    } ptm_state_t;

    typedef struct packed {
        logic               present;
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } entry_t;

endpackage

@@ design/page_table_manager_core.sv @@
// Direct-indexed page table, one entry per page, kept in a synchronous
// 256-entry memory with a registered read, plus a 64-frame used bitmap,
// an entry count and a 32-bit counter of successful inserts. An operation is
// taken when start is high and busy is low; its result appears on status,
// frame_out, hit and insert_count for exactly one cycle with done high and
// must be captured then, since the block cannot be stalled. Insert, lookup,
// remove, invalidate and unused kinds do one memory read, then a check and,
// where needed, a write back. A replace whose old page is present and valid
// reads and writes the old page entry before it reads the new one through
// the same port, then checks the new one and writes it if the check passes;
// any other replace ends after its first check. A new operation may be
// started in the cycle that done is high. No clearing pass is needed after reset.
module page_table_manager_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    kind,
    input  logic [ptm_pkg::PAGE_W-1:0]    page,
    input  logic [ptm_pkg::FRAME_W-1:0]   frame,
    input  logic [ptm_pkg::PAGE_W-1:0]    old_page,
    output logic                          done,
    output logic [2:0]                    status,
    output logic [ptm_pkg::FRAME_W-1:0]   frame_out,
    output logic                          hit,
    output logic [31:0]                   insert_count,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptm_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ptm_pkg::*;

    ptm_state_t          state_reg, state_next;
    logic [2:0]          kind_reg;
    logic [PAGE_W-1:0]   page_reg;
    // old page address of a replace is held beside the new one
    logic [PAGE_W-1:0]   old_page_reg;
    logic [FRAME_W-1:0]  frame_reg;
    logic [FRAME_W-1:0]  rep_frame_reg, rep_frame_next;

    logic [CNT_W-1:0]    num_frames_reg;
    logic [CNT_W-1:0]    lim;

    entry_t              mem [PAGES];
    logic [PAGES-1:0]    written_reg;
    entry_t              rd_data_reg;
    logic                rd_ok_reg;
    entry_t              seen;
    logic [PAGE_W-1:0]   rd_addr;
    logic                mem_we;
    logic [PAGE_W-1:0]   mem_waddr;
    entry_t              mem_wdata;

    logic [FRAMES-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [31:0]         ins_cnt_reg, ins_cnt_next;

    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic [FRAME_W-1:0]  fout_reg, fout_next;
    logic                hit_reg, hit_next;

    logic [FRAME_W-1:0]  ins_frame;
    status_t             ins_status;
    logic                cfg_wr;

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign frame_out    = fout_reg;
    assign hit          = hit_reg;
    assign insert_count = ins_cnt_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr == REG_NUM_FRAMES) ? {{(32-CNT_W){1'b0}}, num_frames_reg} : 32'd0;
    assign lim    = (num_frames_reg > CNT_W'(FRAMES)) ? CNT_W'(FRAMES) : num_frames_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_frames_reg <= NUM_FRAMES_RST;
        end
        else if (cfg_wr && paddr == REG_NUM_FRAMES)
        begin
            num_frames_reg <= pwdata[CNT_W-1:0];
        end
    end

    // page entry memory
    assign rd_addr = (state_reg == ST_IDLE)
                     ? ((kind == OP_REPLACE) ? old_page : page)
                     : page_reg;
    assign seen    = rd_ok_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= written_reg[rd_addr];
            if (mem_we)
            begin
                written_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    // insert checks, shared by insert and the second half of replace
    assign ins_frame = (state_reg == ST_REP_CHK) ? rep_frame_reg : frame_reg;

    always_comb
    begin
        if ({1'b0, ins_frame} >= lim)
        begin
            ins_status = STAT_BAD_FRAME;
        end
        else if (cnt_reg >= lim)
        begin
            ins_status = STAT_FULL;
        end
        else if (used_reg[ins_frame])
        begin
            ins_status = STAT_BUSY;
        end
        else if (seen.present)
        begin
            ins_status = STAT_MAPPED;
        end
        else
        begin
            ins_status = STAT_OK;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rep_frame_next = rep_frame_reg;
        mem_we         = 1'b0;
        mem_waddr      = page_reg;
        mem_wdata      = '0;
        used_next      = used_reg;
        cnt_next       = cnt_reg;
        ins_cnt_next   = ins_cnt_reg;
        done_next      = 1'b0;
        status_next    = STAT_FAULT;
        fout_next      = '0;
        hit_next       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                case (kind_reg)
                    OP_INSERT:
                    begin
                        status_next = ins_status;
                        if (ins_status == STAT_OK)
                        begin
                            mem_we               = 1'b1;
                            mem_wdata            = '{present: 1'b1, valid: 1'b1, frame: ins_frame};
                            used_next[ins_frame] = 1'b1;
                            cnt_next             = cnt_reg + CNT_W'(1);
                            ins_cnt_next         = ins_cnt_reg + 32'd1;
                            fout_next            = ins_frame;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (seen.present && seen.valid)
                        begin
                            status_next = STAT_OK;
                            fout_next   = seen.frame;
                            hit_next    = 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (seen.present)
                        begin
                            mem_we                = 1'b1;
                            used_next[seen.frame] = 1'b0;
                            if (cnt_reg != '0)
                            begin
                                cnt_next = cnt_reg - CNT_W'(1);
                            end
                            status_next = STAT_OK;
                        end
                    end
                    OP_INVALIDATE:
                    begin
                        if (seen.present)
                        begin
                            mem_we      = 1'b1;
                            mem_wdata   = '{present: 1'b1, valid: 1'b0, frame: seen.frame};
                            status_next = STAT_OK;
                        end
                    end
                    OP_REPLACE:
                    begin
                        if (seen.present)
                        begin
                            // evict the old page first
                            mem_we                = 1'b1;
                            mem_waddr             = old_page_reg;
                            used_next[seen.frame] = 1'b0;
                            if (cnt_reg != '0)
                            begin
                                cnt_next = cnt_reg - CNT_W'(1);
                            end
                            if (seen.valid)
                            begin
                                rep_frame_next = seen.frame;
                                state_next     = ST_REP_RD;
                                done_next      = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        status_next = STAT_FAULT;
                    end
                endcase
            end
            ST_REP_RD:
            begin
                state_next = ST_REP_CHK;
            end
            ST_REP_CHK:
            begin
                state_next  = ST_IDLE;
                done_next   = 1'b1;
                status_next = ins_status;
                if (ins_status == STAT_OK)
                begin
                    mem_we               = 1'b1;
                    mem_wdata            = '{present: 1'b1, valid: 1'b1, frame: ins_frame};
                    used_next[ins_frame] = 1'b1;
                    cnt_next             = cnt_reg + CNT_W'(1);
                    ins_cnt_next         = ins_cnt_reg + 32'd1;
                    fout_next            = ins_frame;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            kind_reg     <= kind;
            page_reg     <= page;
            frame_reg    <= frame;
            old_page_reg <= old_page;
        end
        rep_frame_reg <= rep_frame_next;
        fout_reg      <= fout_next;
        hit_reg       <= hit_next;
        status_reg    <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            cnt_reg     <= '0;
            ins_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            cnt_reg     <= cnt_next;
            ins_cnt_reg <= ins_cnt_next;
            done_reg    <= done_next;
        end
    end

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(FRAMES))
        else $error("entry count above frame total");

    a_cnt_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> cnt_reg == CNT_W'($countones(used_reg)))
        else $error("entry count differs from used frames");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && hit_reg |-> status_reg == STAT_OK)
        else $error("hit without ok status");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_EVAL || state_reg == ST_REP_CHK))
        else $error("result without a finished operation");

    a_insert_step: assert property (@(posedge clk) disable iff (!rst_n)
        !done_reg |-> ins_cnt_reg == $past(ins_cnt_reg) || $past(!rst_n))
        else $error("insert counter moved without a result");

endmodule
